/* rtl/core/jct_pkg.sv */
`default_nettype none
package jct_pkg;

  typedef logic [6:0] state_t;
  typedef logic [7:0] char_t;
  typedef logic [3:0] offset_t;

  // character classes of one byte
  typedef struct packed {
    logic ws;
    logic digit;
    logic hex;
    logic ctrl;
    logic expo;
  } char_class_t;

  // dense state codes
  localparam state_t S_EMPTY     = 7'd0;
  localparam state_t S_WS        = 7'd1;
  localparam state_t S_ERROR     = 7'd2;
  localparam state_t S_INVALID   = 7'd3;
  localparam state_t S_OBJ_START = 7'd4;
  localparam state_t S_OBJ_KEY   = 7'd5;
  localparam state_t S_OBJ_COLON = 7'd6;
  localparam state_t S_OBJ_END   = 7'd7;
  localparam state_t S_ARR_START = 7'd8;
  localparam state_t S_ARR_VALUE = 7'd9;
  localparam state_t S_ARR_END   = 7'd10;
  localparam state_t S_COUNT     = 7'd87;

  // group bases
  localparam state_t B_KEY_STR   = 7'd11;
  localparam state_t B_OBJ_STR   = 7'd21;
  localparam state_t B_ARR_STR   = 7'd31;
  localparam state_t B_OBJ_NUM   = 7'd41;
  localparam state_t B_ARR_NUM   = 7'd51;
  localparam state_t B_OBJ_TRUE  = 7'd61;
  localparam state_t B_ARR_TRUE  = 7'd65;
  localparam state_t B_OBJ_FALSE = 7'd69;
  localparam state_t B_ARR_FALSE = 7'd74;
  localparam state_t B_OBJ_NULL  = 7'd79;
  localparam state_t B_ARR_NULL  = 7'd83;

  // string group offsets
  localparam offset_t STR_START     = 4'd0;
  localparam offset_t STR_STRING    = 4'd1;
  localparam offset_t STR_ESC_START = 4'd2;
  localparam offset_t STR_ESC_END   = 4'd3;
  localparam offset_t STR_HEX_START = 4'd4;
  localparam offset_t STR_HEX0      = 4'd5;
  localparam offset_t STR_HEX1      = 4'd6;
  localparam offset_t STR_HEX2      = 4'd7;
  localparam offset_t STR_HEX_END   = 4'd8;
  localparam offset_t STR_END       = 4'd9;

  // number group offsets
  localparam offset_t NUM_START      = 4'd0;
  localparam offset_t NUM_MINUS      = 4'd1;
  localparam offset_t NUM_ZERO       = 4'd2;
  localparam offset_t NUM_NUMBER     = 4'd3;
  localparam offset_t NUM_FRAC_START = 4'd4;
  localparam offset_t NUM_FRACTION   = 4'd5;
  localparam offset_t NUM_EXP_START  = 4'd6;
  localparam offset_t NUM_EXP_SIGNED = 4'd7;
  localparam offset_t NUM_EXPONENT   = 4'd8;
  localparam offset_t NUM_END        = 4'd9;

  // literal group offsets
  localparam state_t LIT_OFF1    = 7'd1;
  localparam state_t LIT_OFF2    = 7'd2;
  localparam state_t LIT_OFF3    = 7'd3;
  localparam state_t LIT_OFF4    = 7'd4;
  localparam state_t TRUE_END    = 7'd3;
  localparam state_t FALSE_END   = 7'd4;
  localparam state_t NULL_END    = 7'd3;

  // characters
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_9      = 8'h39;
  localparam char_t CH_UA     = 8'h41;
  localparam char_t CH_UE     = 8'h45;
  localparam char_t CH_UF     = 8'h46;
  localparam char_t CH_A      = 8'h61;
  localparam char_t CH_B      = 8'h62;
  localparam char_t CH_E      = 8'h65;
  localparam char_t CH_F      = 8'h66;
  localparam char_t CH_L      = 8'h6C;
  localparam char_t CH_N      = 8'h6E;
  localparam char_t CH_R      = 8'h72;
  localparam char_t CH_S      = 8'h73;
  localparam char_t CH_T      = 8'h74;
  localparam char_t CH_U      = 8'h75;
  localparam char_t CH_CTRL_MAX = 8'd31;
  localparam char_t CH_DEL      = 8'd127;

endpackage
`default_nettype wire

/* rtl/core/jct_char_class.sv */
`default_nettype none
module jct_char_class (
  input  wire jct_pkg::char_t       c,
  output jct_pkg::char_class_t      cls
);

  always_comb begin
    cls.ws    = (c == jct_pkg::CH_SPACE) || (c == jct_pkg::CH_TAB) ||
                (c == jct_pkg::CH_LF) || (c == jct_pkg::CH_CR);
    cls.digit = (c >= jct_pkg::CH_0) && (c <= jct_pkg::CH_9);
    cls.hex   = cls.digit ||
                ((c >= jct_pkg::CH_UA) && (c <= jct_pkg::CH_UF)) ||
                ((c >= jct_pkg::CH_A) && (c <= jct_pkg::CH_F));
    cls.ctrl  = (c <= jct_pkg::CH_CTRL_MAX) || (c == jct_pkg::CH_DEL);
    cls.expo  = (c == jct_pkg::CH_E) || (c == jct_pkg::CH_UE);
  end

endmodule
`default_nettype wire

/* rtl/core/jct_next.sv */
`default_nettype none
module jct_next (
  input  wire jct_pkg::state_t      s,
  input  wire jct_pkg::char_t       c,
  input  wire jct_pkg::char_class_t cls,
  output jct_pkg::state_t           nxt
);

  jct_pkg::state_t  wsi;
  jct_pkg::state_t  num_b;
  jct_pkg::offset_t num_off;
  jct_pkg::state_t  num_end;
  jct_pkg::state_t  str_b;
  jct_pkg::offset_t str_off;
  jct_pkg::state_t  vs;
  logic             in_num;
  logic             in_str;
  logic             obj_ctx;
  logic             lit_hit;
  jct_pkg::char_t   lit_char;

  always_comb begin
    wsi = cls.ws ? jct_pkg::S_WS : jct_pkg::S_INVALID;

    // number groups
    in_num  = (s >= jct_pkg::B_OBJ_NUM) &&
              (s <= jct_pkg::B_ARR_NUM + 7'(jct_pkg::NUM_END));
    num_b   = (s < jct_pkg::B_ARR_NUM) ? jct_pkg::B_OBJ_NUM : jct_pkg::B_ARR_NUM;
    num_off = 4'(s - num_b);
    // re-dispatch from number end
    if (num_b == jct_pkg::B_OBJ_NUM) begin
      num_end = (c == jct_pkg::CH_COMMA)  ? jct_pkg::S_OBJ_KEY :
                (c == jct_pkg::CH_RBRACE) ? jct_pkg::S_OBJ_END : wsi;
    end else begin
      num_end = (c == jct_pkg::CH_COMMA)  ? jct_pkg::S_ARR_VALUE :
                (c == jct_pkg::CH_RBRACK) ? jct_pkg::S_ARR_END : wsi;
    end

    // string groups
    in_str  = (s >= jct_pkg::B_KEY_STR) &&
              (s <= jct_pkg::B_ARR_STR + 7'(jct_pkg::STR_END));
    str_b   = (s < jct_pkg::B_OBJ_STR) ? jct_pkg::B_KEY_STR :
              (s < jct_pkg::B_ARR_STR) ? jct_pkg::B_OBJ_STR : jct_pkg::B_ARR_STR;
    str_off = 4'(s - str_b);

    // value start
    obj_ctx = (s == jct_pkg::S_OBJ_COLON);
    priority if (c == jct_pkg::CH_QUOTE) begin
      vs = obj_ctx ? jct_pkg::B_OBJ_STR : jct_pkg::B_ARR_STR;
    end else if (c == jct_pkg::CH_MINUS) begin
      vs = (obj_ctx ? jct_pkg::B_OBJ_NUM : jct_pkg::B_ARR_NUM) + 7'(jct_pkg::NUM_MINUS);
    end else if (c == jct_pkg::CH_0) begin
      vs = (obj_ctx ? jct_pkg::B_OBJ_NUM : jct_pkg::B_ARR_NUM) + 7'(jct_pkg::NUM_ZERO);
    end else if (c == jct_pkg::CH_LBRACE) begin
      vs = jct_pkg::S_OBJ_START;
    end else if (c == jct_pkg::CH_LBRACK) begin
      vs = jct_pkg::S_ARR_START;
    end else if (c == jct_pkg::CH_T) begin
      vs = obj_ctx ? jct_pkg::B_OBJ_TRUE : jct_pkg::B_ARR_TRUE;
    end else if (c == jct_pkg::CH_F) begin
      vs = obj_ctx ? jct_pkg::B_OBJ_FALSE : jct_pkg::B_ARR_FALSE;
    end else if (c == jct_pkg::CH_N) begin
      vs = obj_ctx ? jct_pkg::B_OBJ_NULL : jct_pkg::B_ARR_NULL;
    end else if (cls.digit) begin
      vs = (obj_ctx ? jct_pkg::B_OBJ_NUM : jct_pkg::B_ARR_NUM) + 7'(jct_pkg::NUM_NUMBER);
    end else begin
      vs = wsi;
    end

    // literal letters
    lit_hit  = 1'b1;
    lit_char = jct_pkg::CH_R;
    unique case (s)
      jct_pkg::B_OBJ_TRUE,  jct_pkg::B_ARR_TRUE:                lit_char = jct_pkg::CH_R;
      jct_pkg::B_OBJ_TRUE + jct_pkg::LIT_OFF1,
      jct_pkg::B_ARR_TRUE + jct_pkg::LIT_OFF1:                  lit_char = jct_pkg::CH_U;
      jct_pkg::B_OBJ_TRUE + jct_pkg::LIT_OFF2,
      jct_pkg::B_ARR_TRUE + jct_pkg::LIT_OFF2:                  lit_char = jct_pkg::CH_E;
      jct_pkg::B_OBJ_FALSE, jct_pkg::B_ARR_FALSE:               lit_char = jct_pkg::CH_A;
      jct_pkg::B_OBJ_FALSE + jct_pkg::LIT_OFF1,
      jct_pkg::B_ARR_FALSE + jct_pkg::LIT_OFF1:                 lit_char = jct_pkg::CH_L;
      jct_pkg::B_OBJ_FALSE + jct_pkg::LIT_OFF2,
      jct_pkg::B_ARR_FALSE + jct_pkg::LIT_OFF2:                 lit_char = jct_pkg::CH_S;
      jct_pkg::B_OBJ_FALSE + jct_pkg::LIT_OFF3,
      jct_pkg::B_ARR_FALSE + jct_pkg::LIT_OFF3:                 lit_char = jct_pkg::CH_E;
      jct_pkg::B_OBJ_NULL,  jct_pkg::B_ARR_NULL:                lit_char = jct_pkg::CH_U;
      jct_pkg::B_OBJ_NULL + jct_pkg::LIT_OFF1,
      jct_pkg::B_ARR_NULL + jct_pkg::LIT_OFF1,
      jct_pkg::B_OBJ_NULL + jct_pkg::LIT_OFF2,
      jct_pkg::B_ARR_NULL + jct_pkg::LIT_OFF2:                  lit_char = jct_pkg::CH_L;
      default:                                                  lit_hit = 1'b0;
    endcase

    nxt = jct_pkg::S_INVALID;
    if (s >= jct_pkg::S_COUNT) begin
      nxt = jct_pkg::S_INVALID;
    end else if (in_num) begin
      unique case (num_off)
        jct_pkg::NUM_MINUS: begin
          nxt = (c == jct_pkg::CH_0) ? num_b + 7'(jct_pkg::NUM_ZERO) :
                cls.digit ? num_b + 7'(jct_pkg::NUM_NUMBER) : jct_pkg::S_INVALID;
        end
        jct_pkg::NUM_ZERO: begin
          nxt = (c == jct_pkg::CH_DOT) ? num_b + 7'(jct_pkg::NUM_FRAC_START) :
                cls.expo ? num_b + 7'(jct_pkg::NUM_EXP_START) : num_end;
        end
        jct_pkg::NUM_NUMBER: begin
          nxt = cls.digit ? s :
                (c == jct_pkg::CH_DOT) ? num_b + 7'(jct_pkg::NUM_FRAC_START) :
                cls.expo ? num_b + 7'(jct_pkg::NUM_EXP_START) : num_end;
        end
        jct_pkg::NUM_FRAC_START: begin
          nxt = cls.digit ? num_b + 7'(jct_pkg::NUM_FRACTION) : jct_pkg::S_INVALID;
        end
        jct_pkg::NUM_FRACTION: begin
          nxt = cls.digit ? s :
                cls.expo ? num_b + 7'(jct_pkg::NUM_EXP_START) : num_end;
        end
        jct_pkg::NUM_EXP_START: begin
          nxt = ((c == jct_pkg::CH_PLUS) || (c == jct_pkg::CH_MINUS)) ?
                  num_b + 7'(jct_pkg::NUM_EXP_SIGNED) :
                cls.digit ? num_b + 7'(jct_pkg::NUM_EXPONENT) : jct_pkg::S_INVALID;
        end
        jct_pkg::NUM_EXP_SIGNED: begin
          nxt = cls.digit ? num_b + 7'(jct_pkg::NUM_EXPONENT) : jct_pkg::S_INVALID;
        end
        jct_pkg::NUM_EXPONENT: begin
          nxt = cls.digit ? s : num_end;
        end
        default: nxt = jct_pkg::S_ERROR;  // number start and end given as input
      endcase
    end else begin
      unique case (s)
        jct_pkg::S_OBJ_END, jct_pkg::S_ARR_END: begin
          nxt = cls.ws ? jct_pkg::S_WS : jct_pkg::S_ERROR;
        end
        jct_pkg::S_WS, jct_pkg::S_ERROR: nxt = jct_pkg::S_ERROR;
        jct_pkg::S_EMPTY: begin
          nxt = (c == jct_pkg::CH_LBRACE) ? jct_pkg::S_OBJ_START :
                (c == jct_pkg::CH_LBRACK) ? jct_pkg::S_ARR_START : wsi;
        end
        jct_pkg::S_OBJ_START, jct_pkg::S_OBJ_KEY: begin
          nxt = ((s == jct_pkg::S_OBJ_START) && (c == jct_pkg::CH_RBRACE)) ?
                  jct_pkg::S_OBJ_END :
                (c == jct_pkg::CH_QUOTE) ? jct_pkg::B_KEY_STR : wsi;
        end
        jct_pkg::B_KEY_STR + 7'(jct_pkg::STR_END): begin
          nxt = (c == jct_pkg::CH_COLON) ? jct_pkg::S_OBJ_COLON : wsi;
        end
        jct_pkg::S_OBJ_COLON: nxt = vs;
        jct_pkg::B_OBJ_STR + 7'(jct_pkg::STR_END),
        jct_pkg::B_OBJ_TRUE + jct_pkg::TRUE_END,
        jct_pkg::B_OBJ_FALSE + jct_pkg::FALSE_END,
        jct_pkg::B_OBJ_NULL + jct_pkg::NULL_END: begin
          nxt = (c == jct_pkg::CH_COMMA)  ? jct_pkg::S_OBJ_KEY :
                (c == jct_pkg::CH_RBRACE) ? jct_pkg::S_OBJ_END : wsi;
        end
        jct_pkg::S_ARR_START, jct_pkg::S_ARR_VALUE: begin
          nxt = ((s == jct_pkg::S_ARR_START) && (c == jct_pkg::CH_RBRACK)) ?
                  jct_pkg::S_ARR_END : vs;
        end
        jct_pkg::B_ARR_STR + 7'(jct_pkg::STR_END),
        jct_pkg::B_ARR_TRUE + jct_pkg::TRUE_END,
        jct_pkg::B_ARR_FALSE + jct_pkg::FALSE_END,
        jct_pkg::B_ARR_NULL + jct_pkg::NULL_END: begin
          nxt = (c == jct_pkg::CH_COMMA)  ? jct_pkg::S_ARR_VALUE :
                (c == jct_pkg::CH_RBRACK) ? jct_pkg::S_ARR_END : wsi;
        end
        default: begin
          if (in_str) begin
            unique case (str_off)
              jct_pkg::STR_START, jct_pkg::STR_STRING,
              jct_pkg::STR_ESC_END, jct_pkg::STR_HEX_END: begin
                nxt = (c == jct_pkg::CH_BSLASH) ? str_b + 7'(jct_pkg::STR_ESC_START) :
                      (c == jct_pkg::CH_QUOTE)  ? str_b + 7'(jct_pkg::STR_END) :
                      !cls.ctrl ? str_b + 7'(jct_pkg::STR_STRING) : wsi;
              end
              jct_pkg::STR_ESC_START: begin
                if ((c == jct_pkg::CH_QUOTE) || (c == jct_pkg::CH_BSLASH) ||
                    (c == jct_pkg::CH_SLASH) || (c == jct_pkg::CH_B) ||
                    (c == jct_pkg::CH_F) || (c == jct_pkg::CH_N) ||
                    (c == jct_pkg::CH_R) || (c == jct_pkg::CH_T)) begin
                  nxt = str_b + 7'(jct_pkg::STR_ESC_END);
                end else if (c == jct_pkg::CH_U) begin
                  nxt = str_b + 7'(jct_pkg::STR_HEX_START);
                end else begin
                  nxt = jct_pkg::S_INVALID;
                end
              end
              jct_pkg::STR_HEX_START, jct_pkg::STR_HEX0,
              jct_pkg::STR_HEX1, jct_pkg::STR_HEX2: begin
                nxt = cls.hex ? s + jct_pkg::LIT_OFF1 : jct_pkg::S_INVALID;
              end
              default: nxt = jct_pkg::S_INVALID;
            endcase
          end else if (lit_hit) begin
            nxt = (c == lit_char) ? s + jct_pkg::LIT_OFF1 : jct_pkg::S_INVALID;
          end else begin
            nxt = jct_pkg::S_INVALID;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/json_char_transition.sv */
`default_nettype none
// result: a beat taken at the edge where start is high and busy is low shows its
//   next_state through the input register and the result register, with done high for exactly one cycle
// throughput: one beat per clock; busy is held low, and the transition logic sits
//   between the input register and the result register
// reset: synchronous active-high rst clears the valid and done flags; no results
//   are produced until new beats arrive, and the receiver cannot stall the output
module json_char_transition (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire jct_pkg::state_t  current_state,
  input  wire jct_pkg::char_t   char_byte,
  output logic                  done,
  output jct_pkg::state_t       next_state
);

  // input register stage
  logic                  valid_q;
  jct_pkg::state_t       state_q;
  jct_pkg::char_t        char_q;

  // combinational transition
  jct_pkg::char_class_t  cls;
  jct_pkg::state_t       next_state_next;

  // no internal backpressure: every cycle can take a new beat
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      state_q <= current_state;
      char_q  <= char_byte;
    end
  end

  // classify the byte once, shared by every arm of the transition
  jct_char_class u_char_class (
    .c   (char_q),
    .cls (cls)
  );

  // next-state logic; number end re-dispatch is folded into this one pass
  jct_next u_next (
    .s   (state_q),
    .c   (char_q),
    .cls (cls),
    .nxt (next_state_next)
  );

  // result register: done is a one-cycle strobe per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      next_state <= next_state_next;
    end
  end

`ifndef SYNTHESIS
  // every accepted beat yields its strobe after the input and result registers
  a_beat_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted beat produced no result strobe");

  // result code always a defined state
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (next_state < jct_pkg::S_COUNT))
    else $error("next_state out of code range");

  // unused input codes map to invalid
  a_unused_code: assert property (@(posedge clk) disable iff (rst)
    (valid_q && (state_q >= jct_pkg::S_COUNT)) |=> (next_state == jct_pkg::S_INVALID))
    else $error("unused state code did not give invalid");

  // marker states whitespace and error always lead to error
  a_marker_error: assert property (@(posedge clk) disable iff (rst)
    (valid_q && ((state_q == jct_pkg::S_WS) || (state_q == jct_pkg::S_ERROR)))
      |=> (next_state == jct_pkg::S_ERROR))
    else $error("marker state did not go to error");

  // invalid state is sticky
  a_invalid_sticky: assert property (@(posedge clk) disable iff (rst)
    (valid_q && (state_q == jct_pkg::S_INVALID)) |=> (next_state == jct_pkg::S_INVALID))
    else $error("invalid state left invalid");
`endif

endmodule
`default_nettype wire

/* bench/json_char_transition_tb.sv */
`timescale 1ns / 1ps

module json_char_transition_tb;
  import jct_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int RESULT_LATENCY = 2;     // beat in to done out
  localparam int STALL_LIMIT    = 200;   // cycles with no beat and no result
  localparam int REPORT_LIMIT   = 10;

  // one accepted beat together with the state it must lead to
  typedef struct {
    state_t from_state;
    char_t  ch;
    state_t to_state;
  } transition_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  state_t current_state;
  char_t  char_byte;
  logic   done;
  state_t next_state;

  transition_t pending_q[$];   // transitions still waiting for their result
  int          mismatch_count;
  int          idle_max;       // largest gap the sender draws before a beat
  int          quiet_cycles;

  json_char_transition dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .current_state (current_state),
    .char_byte     (char_byte),
    .done          (done),
    .next_state    (next_state)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // ---------------------------------------------------------------------------
  // character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_blank(char_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_dec(char_t c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_hexd(char_t c);
    return is_dec(c) || (c >= CH_UA && c <= CH_UF) || (c >= CH_A && c <= CH_F);
  endfunction

  // control bytes inside strings; high bytes are ordinary text
  function automatic bit is_ctl(char_t c);
    return c <= CH_CTRL_MAX || c == CH_DEL;
  endfunction

  function automatic bit is_expo(char_t c);
    return c == CH_E || c == CH_UE;
  endfunction

  // a byte nobody accepts: whitespace gets its own marker
  function automatic state_t blank_or_bad(char_t c);
    return is_blank(c) ? S_WS : S_INVALID;
  endfunction

  // first byte of a value after a colon (object) or in an array
  function automatic state_t value_entry(bit in_obj, char_t c);
    state_t num_b;
    num_b = in_obj ? B_OBJ_NUM : B_ARR_NUM;
    case (c)
      CH_QUOTE:  return in_obj ? B_OBJ_STR : B_ARR_STR;
      CH_MINUS:  return num_b + NUM_MINUS;
      CH_0:      return num_b + NUM_ZERO;
      CH_LBRACE: return S_OBJ_START;
      CH_LBRACK: return S_ARR_START;
      CH_T:      return in_obj ? B_OBJ_TRUE : B_ARR_TRUE;
      CH_F:      return in_obj ? B_OBJ_FALSE : B_ARR_FALSE;
      CH_N:      return in_obj ? B_OBJ_NULL : B_ARR_NULL;
      default: begin
        if (is_dec(c)) return num_b + NUM_NUMBER;
        return blank_or_bad(c);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // syntax state that one byte leads to
  // ---------------------------------------------------------------------------
  function automatic state_t predict_next(state_t s, char_t c);
    state_t  base;
    offset_t off;
    char_t   spell [4];

    // unused codes
    if (s >= S_COUNT) return S_INVALID;

    // numbers: a byte that does not extend the number closes it and is
    // then handled as if seen in the number end state
    if (s >= B_OBJ_NUM && s < B_OBJ_TRUE) begin
      base = (s < B_ARR_NUM) ? B_OBJ_NUM : B_ARR_NUM;
      off  = offset_t'(s - base);
      case (off)
        NUM_MINUS: begin
          if (c == CH_0) return base + NUM_ZERO;
          return is_dec(c) ? base + NUM_NUMBER : S_INVALID;
        end
        NUM_ZERO: begin
          if (c == CH_DOT) return base + NUM_FRAC_START;
          if (is_expo(c)) return base + NUM_EXP_START;
        end
        NUM_NUMBER: begin
          if (is_dec(c)) return s;
          if (c == CH_DOT) return base + NUM_FRAC_START;
          if (is_expo(c)) return base + NUM_EXP_START;
        end
        NUM_FRAC_START: return is_dec(c) ? base + NUM_FRACTION : S_INVALID;
        NUM_FRACTION: begin
          if (is_dec(c)) return s;
          if (is_expo(c)) return base + NUM_EXP_START;
        end
        NUM_EXP_START: begin
          if (c == CH_PLUS || c == CH_MINUS) return base + NUM_EXP_SIGNED;
          return is_dec(c) ? base + NUM_EXPONENT : S_INVALID;
        end
        NUM_EXP_SIGNED: return is_dec(c) ? base + NUM_EXPONENT : S_INVALID;
        NUM_EXPONENT: begin
          if (is_dec(c)) return s;
        end
        // start and end given as input are never valid
        default: return S_ERROR;
      endcase
      if (base == B_OBJ_NUM) begin
        if (c == CH_COMMA) return S_OBJ_KEY;
        if (c == CH_RBRACE) return S_OBJ_END;
        return blank_or_bad(c);
      end
      if (c == CH_COMMA) return S_ARR_VALUE;
      if (c == CH_RBRACK) return S_ARR_END;
      return blank_or_bad(c);
    end

    case (s)
      // closed container takes nothing but whitespace
      S_OBJ_END, S_ARR_END: return is_blank(c) ? S_WS : S_ERROR;
      S_WS, S_ERROR:        return S_ERROR;
      S_EMPTY: begin
        if (c == CH_LBRACE) return S_OBJ_START;
        if (c == CH_LBRACK) return S_ARR_START;
        return blank_or_bad(c);
      end
      S_OBJ_START, S_OBJ_KEY: begin
        if (s == S_OBJ_START && c == CH_RBRACE) return S_OBJ_END;
        return c == CH_QUOTE ? B_KEY_STR : blank_or_bad(c);
      end
      B_KEY_STR + STR_END: return c == CH_COLON ? S_OBJ_COLON : blank_or_bad(c);
      S_OBJ_COLON:         return value_entry(1'b1, c);
      B_OBJ_STR + STR_END, B_OBJ_TRUE + TRUE_END, B_OBJ_FALSE + FALSE_END,
      B_OBJ_NULL + NULL_END: begin
        if (c == CH_COMMA) return S_OBJ_KEY;
        if (c == CH_RBRACE) return S_OBJ_END;
        return blank_or_bad(c);
      end
      S_ARR_START, S_ARR_VALUE: begin
        if (s == S_ARR_START && c == CH_RBRACK) return S_ARR_END;
        return value_entry(1'b0, c);
      end
      B_ARR_STR + STR_END, B_ARR_TRUE + TRUE_END, B_ARR_FALSE + FALSE_END,
      B_ARR_NULL + NULL_END: begin
        if (c == CH_COMMA) return S_ARR_VALUE;
        if (c == CH_RBRACK) return S_ARR_END;
        return blank_or_bad(c);
      end
      default: ;
    endcase

    // strings: key, object value and array value groups share one layout
    if (s >= B_KEY_STR && s < B_OBJ_NUM) begin
      base = (s < B_OBJ_STR) ? B_KEY_STR : (s < B_ARR_STR) ? B_OBJ_STR : B_ARR_STR;
      off  = offset_t'(s - base);
      case (off)
        STR_START, STR_STRING, STR_ESC_END, STR_HEX_END: begin
          if (c == CH_BSLASH) return base + STR_ESC_START;
          if (c == CH_QUOTE) return base + STR_END;
          if (!is_ctl(c)) return base + STR_STRING;
          return blank_or_bad(c);
        end
        STR_ESC_START: begin
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
              return base + STR_ESC_END;
            CH_U:    return base + STR_HEX_START;
            default: return S_INVALID;
          endcase
        end
        STR_HEX_START, STR_HEX0, STR_HEX1, STR_HEX2:
          return is_hexd(c) ? state_t'(s + 1) : S_INVALID;
        default: return S_INVALID;
      endcase
    end

    // literals: the end states were handled above
    if (s >= B_OBJ_TRUE) begin
      spell[3] = CH_E;
      if (s < B_OBJ_FALSE) begin
        base = (s < B_ARR_TRUE) ? B_OBJ_TRUE : B_ARR_TRUE;
        spell[0] = CH_R; spell[1] = CH_U; spell[2] = CH_E;
      end else if (s < B_OBJ_NULL) begin
        base = (s < B_ARR_FALSE) ? B_OBJ_FALSE : B_ARR_FALSE;
        spell[0] = CH_A; spell[1] = CH_L; spell[2] = CH_S;
      end else begin
        base = (s < B_ARR_NULL) ? B_OBJ_NULL : B_ARR_NULL;
        spell[0] = CH_U; spell[1] = CH_L; spell[2] = CH_L;
      end
      return (c == spell[(s - base) & 3]) ? state_t'(s + 1) : S_INVALID;
    end

    // invalid stays invalid
    return S_INVALID;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every done beat against the oldest pending transition,
  // then the beat taken at this same edge is queued behind it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    transition_t t;
    if (!rst) begin
      if (done) begin
        if (pending_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result: next_state %0d", $time, next_state);
        end else begin
          t = pending_q.pop_front();
          if (next_state !== t.to_state) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("[%0t] next_state mismatch: state %0d char 0x%02h expected %0d got %0d",
                       $time, t.from_state, t.ch, t.to_state, next_state);
          end
        end
      end
      if (start && !busy) begin
        t.from_state = current_state;
        t.ch         = char_byte;
        t.to_state   = predict_next(current_state, char_byte);
        pending_q.push_back(t);
      end
    end
  end

  // watchdog on cycles with neither a beat in nor a result out
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // one beat: optional idle gap with junk on the inputs, then hold until taken
  task automatic send_char(state_t s, char_t c);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      @(negedge clk);
      start         <= 1'b0;
      current_state <= state_t'($urandom);
      char_byte     <= char_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    current_state <= s;
    char_byte     <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender stops until every pending result is back, then the pipe empties
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // byte from a pool weighted toward json punctuation, digits and letters
  function automatic char_t pick_char();
    case ($urandom_range(0, 39))
      0:          return CH_LBRACE;
      1:          return CH_RBRACE;
      2:          return CH_LBRACK;
      3:          return CH_RBRACK;
      4:          return CH_COLON;
      5:          return CH_COMMA;
      6, 7:       return CH_QUOTE;
      8:          return CH_BSLASH;
      9:          return CH_SLASH;
      10:         return CH_MINUS;
      11:         return CH_PLUS;
      12:         return CH_DOT;
      13, 14, 15: return CH_0 + char_t'($urandom_range(0, 9));
      16:         return CH_0;
      17:         return CH_E;
      18:         return CH_UE;
      19:         return CH_A;
      20:         return CH_B;
      21:         return CH_F;
      22:         return CH_L;
      23:         return CH_N;
      24:         return CH_R;
      25:         return CH_S;
      26:         return CH_T;
      27:         return CH_U;
      28:         return CH_UA + char_t'($urandom_range(0, 5));
      29:         return CH_A + char_t'($urandom_range(0, 5));
      30:         return CH_SPACE;
      31:         return CH_TAB;
      32:         return CH_LF;
      33:         return CH_CR;
      34:         return char_t'($urandom_range(128, 255));
      35:         return char_t'($urandom_range(0, 31));
      36:         return CH_DEL;
      default:    return char_t'($urandom_range(32, 126));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and each corner of the state machine, back to back
  task automatic test_directed();
    idle_max = 0;
    send_char(S_EMPTY, 8'h00);
    send_char(S_EMPTY, 8'hFF);
    send_char(S_EMPTY, CH_LBRACE);
    send_char(S_EMPTY, CH_LBRACK);
    send_char(S_EMPTY, CH_SPACE);
    // tab inside a string reads as whitespace
    send_char(B_OBJ_STR + STR_STRING, CH_TAB);
    // high byte is plain text, del and low bytes are control
    send_char(B_ARR_STR + STR_STRING, 8'h80);
    send_char(B_KEY_STR + STR_START, CH_DEL);
    send_char(B_KEY_STR + STR_STRING, CH_CTRL_MAX);
    // closed container
    send_char(S_OBJ_END, CH_LF);
    send_char(S_ARR_END, CH_RBRACK);
    // marker states
    send_char(S_WS, CH_SPACE);
    send_char(S_ERROR, CH_LBRACE);
    send_char(S_INVALID, CH_SPACE);
    // number start and end as input
    send_char(B_OBJ_NUM + NUM_START, CH_0);
    send_char(B_ARR_NUM + NUM_END, CH_COMMA);
    // number closed by the byte that follows it
    send_char(B_OBJ_NUM + NUM_NUMBER, CH_RBRACE);
    send_char(B_ARR_NUM + NUM_EXPONENT, CH_CR);
    // unused codes
    send_char(S_COUNT, CH_LBRACE);
    send_char(7'h7F, 8'hFF);
    send_char(B_ARR_STR + STR_ESC_START, CH_U);
    send_char(B_OBJ_STR + STR_HEX2, CH_UF);
    send_char(B_ARR_NULL + NULL_END, CH_RBRACK);
    send_char(B_OBJ_FALSE + LIT_OFF3, CH_E);
    send_char(S_OBJ_COLON, CH_T);
  endtask

  // chained walks: each beat starts from the state the last one reached (whitespace keeps
  // it, an error restarts the walk), and most bytes are chosen so that the walk keeps going
  task automatic test_document_walks(int count);
    state_t s;
    state_t nxt;
    char_t  c;
    s = S_EMPTY;
    for (int i = 0; i < count; i++) begin
      idle_max = (i < count / 2) ? 8 : ((i / 50) % 2 == 0 ? 0 : 8);
      if ($urandom_range(0, 99) < 85) begin
        c = pick_char();
        for (int k = 0; k < 12; k++) begin
          nxt = predict_next(s, c);
          if (nxt != S_WS && nxt != S_ERROR && nxt != S_INVALID) break;
          c = pick_char();
        end
      end else begin
        c = char_t'($urandom_range(0, 255));
      end
      send_char(s, c);
      nxt = predict_next(s, c);
      if (nxt == S_WS) begin
        // whitespace leaves the walk where it was
      end else if (nxt == S_ERROR || nxt == S_INVALID) begin
        case ($urandom_range(0, 3))
          0:       s = S_EMPTY;
          1:       s = S_OBJ_COLON;
          2:       s = S_ARR_VALUE;
          default: s = state_t'($urandom_range(0, S_COUNT - 1));
        endcase
      end else begin
        s = nxt;
      end
    end
  endtask

  // any state code against any byte
  task automatic test_random_pairs(int count);
    for (int i = 0; i < count; i++) begin
      idle_max = ((i / 40) % 3 == 1) ? 0 : 8;
      send_char(state_t'($urandom_range(0, 127)), char_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    current_state  = S_EMPTY;
    char_byte      = '0;
    mismatch_count = 0;
    idle_max       = 0;
    quiet_cycles   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    drain_results();
    test_document_walks(700);
    drain_results();
    test_random_pairs(425);
    drain_results();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
